>>> sv/assert_macros.svh
// Assertion macros shared by the RTL of the pulse scaler.
// Needs nothing else; the macros expand to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`endif

// Condition that must never be seen at a clock edge outside reset.
`ifndef SYNTH
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

>>> sv/rcps_pkg.sv
// Types and constants of the RC channel pulse scaler.
// No dependencies; used by the top level and the testbench.
package rcps_pkg;

  localparam int DATA_W = 32;
  localparam int ADDR_W = 5;
  localparam int DB_W   = 10;
  localparam int FS_W   = 14;
  localparam int OUT_W  = 16;
  localparam int PCT_W  = 7;
  localparam int N_LANES = 4;

  // Divider lanes
  localparam int LANE_CV = 0;
  localparam int LANE_NP = 1;
  localparam int LANE_ND = 2;
  localparam int LANE_PC = 3;

  localparam int Q_ONE       = 16384;
  localparam int PCT_FULL    = 100;
  localparam int CV_POS_MAX  = 32767;
  localparam int CV_NEG_MAG  = 32768;

  localparam int RST_PULSE_MIN  = 1000;
  localparam int RST_PULSE_MAX  = 2000;
  localparam int RST_PULSE_TRIM = 1500;
  localparam int RST_DEAD_BAND  = 20;
  localparam int RST_FULL_SCALE = 4500;

  typedef enum logic [2:0] {
    REG_PULSE_MIN  = 3'd0,
    REG_PULSE_MAX  = 3'd1,
    REG_PULSE_TRIM = 3'd2,
    REG_DEAD_BAND  = 3'd3,
    REG_INVERT     = 3'd4,
    REG_FULL_SCALE = 3'd5,
    REG_SCALE_MODE = 3'd6
  } rcps_reg_t;

  // Side information that rides along with an item through the divider
  typedef struct packed {
    logic cv_neg;
    logic np_neg;
    logic nd_neg;
    logic pc_fix;
    logic pc_full;
  } rcps_tag_t;

endpackage

>>> sv/rcps_pulse_if.sv
// Input channel of the pulse scaler: one measured pulse width per transfer.
// Standalone; width follows PULSE_BITS.
interface rcps_pulse_if #(parameter int PULSE_BITS = 12);
  logic                  valid;
  logic                  ready;
  logic [PULSE_BITS-1:0] pulse_width;

  modport source (output valid, output pulse_width, input ready);
  modport sink   (input valid, input pulse_width, output ready);
endinterface

>>> sv/rcps_result_if.sv
// Output channel of the pulse scaler: four scaled readings per transfer.
// Standalone; field widths are fixed.
interface rcps_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] control_value;
  logic signed [15:0] norm_plain;
  logic signed [15:0] norm_dead;
  logic        [6:0]  percent;

  modport source (output valid, output control_value, output norm_plain,
                  output norm_dead, output percent, input ready);
  modport sink   (input valid, input control_value, input norm_plain,
                  input norm_dead, input percent, output ready);
endinterface

>>> sv/rcps_div_pipe.sv
// Pipelined restoring divider, several unsigned lanes side by side, one
// quotient bit per stage. Uses assert_macros.svh.
`include "assert_macros.svh"

module rcps_div_pipe #(
  parameter int NW    = 27,
  parameter int DW    = 13,
  parameter int TW    = 5,
  parameter int LANES = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [LANES-1:0][NW-1:0]   num_in,
  input  logic [LANES-1:0][DW-1:0]   den_in,
  input  logic [TW-1:0]              tag_in,
  output logic                       out_valid,
  output logic [LANES-1:0][NW-1:0]   q_out,
  output logic [TW-1:0]              tag_out
);

  logic [NW-1:0]                 v;
  logic [LANES-1:0][DW-1:0]      rem  [NW];
  logic [LANES-1:0][NW-1:0]      nsh  [NW];
  logic [LANES-1:0][NW-1:0]      q    [NW];
  logic [LANES-1:0][DW-1:0]      d    [NW];
  logic [TW-1:0]                 tag  [NW];

  logic [LANES-1:0][DW-1:0]      rem_next [NW];
  logic [LANES-1:0][NW-1:0]      nsh_next [NW];
  logic [LANES-1:0][NW-1:0]      q_next   [NW];
  logic                          den_ok;
  logic                          rem_ok;

  always_comb begin
    logic [DW-1:0] src_rem;
    logic [NW-1:0] src_n;
    logic [NW-1:0] src_q;
    logic [DW-1:0] src_d;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    for (int s = 0; s < NW; s++) begin
      for (int l = 0; l < LANES; l++) begin
        if (s == 0) begin
          src_rem = '0;
          src_n   = num_in[l];
          src_q   = '0;
          src_d   = den_in[l];
        end else begin
          src_rem = rem[s-1][l];
          src_n   = nsh[s-1][l];
          src_q   = q[s-1][l];
          src_d   = d[s-1][l];
        end
        // shift in the next numerator bit, subtract when it fits
        trial = {src_rem, src_n[NW-1]};
        diff  = trial - {1'b0, src_d};
        ge    = (trial >= {1'b0, src_d});
        rem_next[s][l] = ge ? diff[DW-1:0] : trial[DW-1:0];
        nsh_next[s][l] = {src_n[NW-2:0], 1'b0};
        q_next[s][l]   = {src_q[NW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NW-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NW; s++) begin
        rem[s] <= rem_next[s];
        nsh[s] <= nsh_next[s];
        q[s]   <= q_next[s];
        if (s == 0) begin
          d[s]   <= den_in;
          tag[s] <= tag_in;
        end else begin
          d[s]   <= d[s-1];
          tag[s] <= tag[s-1];
        end
      end
    end
  end

  assign out_valid = v[NW-1];
  assign q_out     = q[NW-1];
  assign tag_out   = tag[NW-1];

  always_comb begin
    den_ok = 1'b1;
    rem_ok = 1'b1;
    for (int l = 0; l < LANES; l++) begin
      if (den_in[l] == '0) den_ok = 1'b0;
      if (rem[NW-1][l] >= d[NW-1][l]) rem_ok = 1'b0;
    end
  end

  `ASSERT_IMPL(a_den_nonzero, clk, rst, (in_valid && en) |-> den_ok)
  `ASSERT_IMPL(a_rem_below_den, clk, rst, out_valid |-> rem_ok)
  `ASSERT_IMPL(a_hold_on_stall, clk, rst, (!en && out_valid) |=> $stable(q[NW-1]))

endmodule

>>> sv/rc_channel_pulse_scaler_unit.sv
// RC channel pulse scaler: top level with APB register file and pipeline.
// Depends on rcps_pkg, rcps_pulse_if, rcps_result_if, rcps_div_pipe and
// assert_macros.svh.
//
// Takes one pulse width per transfer and returns one result per transfer:
// the control value (angle about trim with dead zone, or range above the
// minimum), two Q2.14 normalized deflections and a 0..100 percent. Items
// stream at one per clock while the sink takes results. The pipeline, where
// NW = max(PULSE_BITS, 10) + 15, is one decode stage, one scaling
// stage with the full_scale multiplier, NW stages of the four-lane restoring
// divider (one quotient bit per stage), and the output register. When the
// result is held by the sink the whole pipeline holds, and the input is not
// ready in that cycle. Configuration registers sit at byte address 4*index
// and must only be written while no item is in flight.
`include "assert_macros.svh"

module rc_channel_pulse_scaler_unit #(
  parameter int PULSE_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rcps_pkg::ADDR_W-1:0] paddr,
  input  logic [rcps_pkg::DATA_W-1:0] pwdata,
  output logic [rcps_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  rcps_pulse_if.sink                  pulse,
  rcps_result_if.source               result
);

  import rcps_pkg::*;

  localparam int PB = PULSE_BITS;
  // Magnitude width of any pulse-domain difference
  localparam int E  = ((PB > DB_W) ? PB : DB_W) + 1;
  localparam int SW = E + 2;
  localparam int DW = E;
  localparam int NW = E + FS_W;
  localparam int TW = $bits(rcps_tag_t);

  // --------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------
  logic [PB-1:0]   cfg_min;
  logic [PB-1:0]   cfg_max;
  logic [PB-1:0]   cfg_trim;
  logic [DB_W-1:0] cfg_dead;
  logic            cfg_inv;
  logic [FS_W-1:0] cfg_fs;
  logic            cfg_mode;
  logic [2:0]      reg_idx;
  logic            wr_en;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_min  <= PB'(RST_PULSE_MIN);
      cfg_max  <= PB'(RST_PULSE_MAX);
      cfg_trim <= PB'(RST_PULSE_TRIM);
      cfg_dead <= DB_W'(RST_DEAD_BAND);
      cfg_inv  <= 1'b0;
      cfg_fs   <= FS_W'(RST_FULL_SCALE);
      cfg_mode <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PULSE_MIN:  cfg_min  <= pwdata[PB-1:0];
        REG_PULSE_MAX:  cfg_max  <= pwdata[PB-1:0];
        REG_PULSE_TRIM: cfg_trim <= pwdata[PB-1:0];
        REG_DEAD_BAND:  cfg_dead <= pwdata[DB_W-1:0];
        REG_INVERT:     cfg_inv  <= pwdata[0];
        REG_FULL_SCALE: cfg_fs   <= pwdata[FS_W-1:0];
        REG_SCALE_MODE: cfg_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PULSE_MIN:  prdata = DATA_W'(cfg_min);
      REG_PULSE_MAX:  prdata = DATA_W'(cfg_max);
      REG_PULSE_TRIM: prdata = DATA_W'(cfg_trim);
      REG_DEAD_BAND:  prdata = DATA_W'(cfg_dead);
      REG_INVERT:     prdata = DATA_W'(cfg_inv);
      REG_FULL_SCALE: prdata = DATA_W'(cfg_fs);
      REG_SCALE_MODE: prdata = DATA_W'(cfg_mode);
      default:        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------
  // Pipeline control: every stage advances together unless the output
  // register holds a result that the sink does not take.
  // --------------------------------------------------------------------
  logic en;
  logic vo;

  assign en          = !vo || result.ready;
  assign pulse.ready = en;

  // --------------------------------------------------------------------
  // Stage 1: compare against the calibration points, pick numerator and
  // divisor magnitudes per lane, and the signs to apply after division.
  // A lane that yields zero gets numerator 0 over divisor 1.
  // --------------------------------------------------------------------
  function automatic logic [DW-1:0] mag(input logic signed [SW-1:0] x);
    logic signed [SW-1:0] t;
    t = x[SW-1] ? -x : x;
    return t[DW-1:0];
  endfunction

  logic signed [SW-1:0] p, mn, mx, tr, db, hi, lo, r, rlo, dd;
  logic [N_LANES-1:0][DW-1:0] c_num, c_den;
  rcps_tag_t c_tag;

  always_comb begin
    p  = $signed({{(SW-PB){1'b0}}, pulse.pulse_width});
    mn = $signed({{(SW-PB){1'b0}}, cfg_min});
    mx = $signed({{(SW-PB){1'b0}}, cfg_max});
    tr = $signed({{(SW-PB){1'b0}}, cfg_trim});
    db = $signed({{(SW-DB_W){1'b0}}, cfg_dead});
    hi = tr + db;
    lo = tr - db;
    c_num = '0;
    for (int l = 0; l < N_LANES; l++) c_den[l] = DW'(1);
    c_tag = '0;
    r   = p;
    rlo = mn + db;
    dd  = '0;

    // Control value
    if (cfg_mode) begin
      // clamp low bound first, then high bound
      if (p < mn) r = mn;
      else if (p > mx) r = mx;
      if (cfg_inv) r = mx - (r - mn);
      dd = mx - rlo;
      if ((r > rlo) && (dd > 0)) begin
        c_num[LANE_CV] = mag(r - rlo);
        c_den[LANE_CV] = mag(dd);
      end
    end else if ((p > hi) && (mx != hi)) begin
      dd = mx - hi;
      c_num[LANE_CV] = mag(p - hi);
      c_den[LANE_CV] = mag(dd);
      c_tag.cv_neg   = dd[SW-1] ^ cfg_inv;
    end else if ((p < lo) && (lo != mn)) begin
      dd = lo - mn;
      c_num[LANE_CV] = mag(lo - p);
      c_den[LANE_CV] = mag(dd);
      c_tag.cv_neg   = !dd[SW-1] ^ cfg_inv;
    end

    // Normalized, no dead zone
    if (p < tr) begin
      if (mn < tr) begin
        c_num[LANE_NP] = mag(tr - p);
        c_den[LANE_NP] = mag(tr - mn);
        c_tag.np_neg   = !cfg_inv;
      end
    end else if (mx > tr) begin
      c_num[LANE_NP] = mag(p - tr);
      c_den[LANE_NP] = mag(mx - tr);
      c_tag.np_neg   = cfg_inv;
    end

    // Normalized outside the dead zone
    if ((p < lo) && (lo > mn)) begin
      c_num[LANE_ND] = mag(lo - p);
      c_den[LANE_ND] = mag(lo - mn);
      c_tag.nd_neg   = !cfg_inv;
    end else if ((p > hi) && (mx > hi)) begin
      c_num[LANE_ND] = mag(p - hi);
      c_den[LANE_ND] = mag(mx - hi);
      c_tag.nd_neg   = cfg_inv;
    end

    // Percent: ends are fixed, the middle is divided
    if (p <= mn) begin
      c_tag.pc_fix  = 1'b1;
      c_tag.pc_full = cfg_inv;
    end else if (p >= mx) begin
      c_tag.pc_fix  = 1'b1;
      c_tag.pc_full = !cfg_inv;
    end else begin
      c_num[LANE_PC] = mag(p - mn);
      c_den[LANE_PC] = mag(mx - mn);
    end
  end

  logic                       v1;
  logic [N_LANES-1:0][DW-1:0] s1_num, s1_den;
  rcps_tag_t                  s1_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= pulse.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_num <= c_num;
      s1_den <= c_den;
      s1_tag <= c_tag;
    end
  end

  // --------------------------------------------------------------------
  // Stage 2: scale the numerators (full_scale, Q2.14 one, 100).
  // --------------------------------------------------------------------
  logic [N_LANES-1:0][NW-1:0] c2_num;
  logic [NW-1:0]              fs_ext, cv_ext, pc_ext;

  always_comb begin
    fs_ext = {{(NW-FS_W){1'b0}}, cfg_fs};
    cv_ext = {{(NW-DW){1'b0}}, s1_num[LANE_CV]};
    pc_ext = {{(NW-DW){1'b0}}, s1_num[LANE_PC]};
    c2_num[LANE_CV] = fs_ext * cv_ext;
    c2_num[LANE_NP] = {s1_num[LANE_NP], {FS_W{1'b0}}};
    c2_num[LANE_ND] = {s1_num[LANE_ND], {FS_W{1'b0}}};
    // times 100 as 64 + 32 + 4
    c2_num[LANE_PC] = (pc_ext << 6) + (pc_ext << 5) + (pc_ext << 2);
  end

  logic                       v2;
  logic [N_LANES-1:0][NW-1:0] s2_num;
  logic [N_LANES-1:0][DW-1:0] s2_den;
  rcps_tag_t                  s2_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_num <= c2_num;
      s2_den <= s1_den;
      s2_tag <= s1_tag;
    end
  end

  // --------------------------------------------------------------------
  // Divider: all four lanes in lock step
  // --------------------------------------------------------------------
  logic                       div_valid;
  logic [N_LANES-1:0][NW-1:0] div_q;
  logic [TW-1:0]              div_tag_bits;
  rcps_tag_t                  div_tag;

  rcps_div_pipe #(
    .NW    (NW),
    .DW    (DW),
    .TW    (TW),
    .LANES (N_LANES)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v2),
    .num_in    (s2_num),
    .den_in    (s2_den),
    .tag_in    (s2_tag),
    .out_valid (div_valid),
    .q_out     (div_q),
    .tag_out   (div_tag_bits)
  );

  assign div_tag = rcps_tag_t'(div_tag_bits);

  // --------------------------------------------------------------------
  // Output stage: apply signs, saturate, resolve the percent ends.
  // --------------------------------------------------------------------
  logic [NW-1:0]        q_cv, q_np, q_nd;
  logic [OUT_W-1:0]     m_np, m_nd, cv_c, np_c, nd_c;
  logic [PCT_W-1:0]     q_pc, pc_c;

  always_comb begin
    q_cv = div_q[LANE_CV];
    q_np = div_q[LANE_NP];
    q_nd = div_q[LANE_ND];
    q_pc = div_q[LANE_PC][PCT_W-1:0];

    if (div_tag.cv_neg) begin
      cv_c = (q_cv > NW'(CV_NEG_MAG)) ? OUT_W'(CV_NEG_MAG)
                                      : OUT_W'(0) - q_cv[OUT_W-1:0];
    end else begin
      cv_c = (q_cv > NW'(CV_POS_MAX)) ? OUT_W'(CV_POS_MAX) : q_cv[OUT_W-1:0];
    end

    m_np = (q_np > NW'(Q_ONE)) ? OUT_W'(Q_ONE) : q_np[OUT_W-1:0];
    m_nd = (q_nd > NW'(Q_ONE)) ? OUT_W'(Q_ONE) : q_nd[OUT_W-1:0];
    np_c = div_tag.np_neg ? OUT_W'(0) - m_np : m_np;
    nd_c = div_tag.nd_neg ? OUT_W'(0) - m_nd : m_nd;

    if (div_tag.pc_fix) begin
      pc_c = div_tag.pc_full ? PCT_W'(PCT_FULL) : '0;
    end else if (cfg_inv) begin
      pc_c = PCT_W'(PCT_FULL) - q_pc;
    end else begin
      pc_c = q_pc;
    end
  end

  logic signed [OUT_W-1:0] cv_q, np_q, nd_q;
  logic [PCT_W-1:0]        pc_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (en) begin
      vo <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cv_q <= $signed(cv_c);
      np_q <= $signed(np_c);
      nd_q <= $signed(nd_c);
      pc_q <= pc_c;
    end
  end

  assign result.valid         = vo;
  assign result.control_value = cv_q;
  assign result.norm_plain    = np_q;
  assign result.norm_dead     = nd_q;
  assign result.percent       = pc_q;

  `ASSERT_NEVER(a_pct_range, clk, rst, vo && (pc_q > PCT_W'(PCT_FULL)))
  `ASSERT_IMPL(a_np_range, clk, rst, vo |-> ((np_q >= -16'sd16384) && (np_q <= 16'sd16384)))
  `ASSERT_IMPL(a_nd_range, clk, rst, vo |-> ((nd_q >= -16'sd16384) && (nd_q <= 16'sd16384)))

endmodule

>>> verif/rcps_tb_pkg.sv
// Shared constants of the pulse scaler testbench.
// Depends on rcps_pkg.
`timescale 1ns / 1ps
package rcps_tb_pkg;
  import rcps_pkg::*;

  localparam int TB_PULSE_BITS = 12;
  localparam int DRAIN_CYCLES  = 40;
  localparam int WATCHDOG_MAX  = 20000;

  // One set of channel calibration values
  typedef struct {
    int unsigned pulse_min;
    int unsigned pulse_max;
    int unsigned pulse_trim;
    int unsigned dead_band;
    int unsigned invert;
    int unsigned full_scale;
    int unsigned scale_mode;
  } rcps_cal_t;
endpackage

>>> verif/rcps_reading_chk.sv
// Checker of the pulse scaler: watches both channels, predicts each reading.
// Depends on rcps_pkg, rcps_tb_pkg and the two channel interfaces.
`timescale 1ns / 1ps
module rcps_reading_chk
  import rcps_pkg::*;
  import rcps_tb_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  rcps_cal_t       cal,
  rcps_pulse_if.sink      pulse_mon,
  rcps_result_if.sink     result_mon,
  output int              fail_count,
  output int              pending
);

  typedef struct {
    logic signed [15:0] control_value;
    logic signed [15:0] norm_plain;
    logic signed [15:0] norm_dead;
    logic        [6:0]  percent;
  } reading_t;

  reading_t reading_q[$];

  function automatic longint sat(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint q_ratio(longint num, longint den);
    longint q;
    if (den == 0) return 0;
    q = (num * Q_ONE) / den;
    if (cal.invert != 0) q = -q;
    return sat(q, -Q_ONE, Q_ONE);
  endfunction

  function automatic reading_t scale_pulse(longint p);
    longint mn, mx, tr, db, fs, hi, lo, r, cv, np, nd, pc;
    reading_t rd;
    mn = cal.pulse_min; mx = cal.pulse_max; tr = cal.pulse_trim;
    db = cal.dead_band; fs = cal.full_scale;
    hi = tr + db; lo = tr - db;
    cv = 0;
    if (cal.scale_mode == 0) begin
      if (p > hi && mx != hi) cv = (fs * (p - hi)) / (mx - hi);
      else if (p < lo && lo != mn) cv = (fs * (p - lo)) / (lo - mn);
      if (cal.invert != 0) cv = -cv;
    end else begin
      r = p;
      if (r < mn) r = mn;
      else if (r > mx) r = mx;
      if (cal.invert != 0) r = mx - (r - mn);
      if (r > mn + db && mx - (mn + db) > 0) cv = (fs * (r - mn - db)) / (mx - mn - db);
    end
    cv = sat(cv, -32768, 32767);
    // plain normalized deflection, degenerate side gives zero
    if (p < tr) np = (mn >= tr) ? 0 : q_ratio(p - tr, tr - mn);
    else np = (mx <= tr) ? 0 : q_ratio(p - tr, mx - tr);
    if (p < lo && lo > mn) nd = q_ratio(p - lo, lo - mn);
    else if (p > hi && mx > hi) nd = q_ratio(p - hi, mx - hi);
    else nd = 0;
    if (p <= mn) pc = (cal.invert != 0) ? 100 : 0;
    else if (p >= mx) pc = (cal.invert != 0) ? 0 : 100;
    else begin
      pc = (100 * (p - mn)) / (mx - mn);
      if (cal.invert != 0) pc = 100 - pc;
    end
    rd.control_value = cv[15:0];
    rd.norm_plain = np[15:0];
    rd.norm_dead = nd[15:0];
    rd.percent = pc[6:0];
    return rd;
  endfunction

  assign pending = reading_q.size();

  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      reading_q.delete();
      fail_count <= 0;
    end else begin
      if (pulse_mon.valid && pulse_mon.ready)
        reading_q.push_back(scale_pulse(longint'(pulse_mon.pulse_width)));
      if (result_mon.valid && result_mon.ready) begin
        if (reading_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result transfer at %0t", $realtime);
        end else begin
          want = reading_q.pop_front();
          if (want.control_value !== result_mon.control_value ||
              want.norm_plain !== result_mon.norm_plain ||
              want.norm_dead !== result_mon.norm_dead ||
              want.percent !== result_mon.percent) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: exp cv=%0d np=%0d nd=%0d pc=%0d got cv=%0d np=%0d nd=%0d pc=%0d",
                       want.control_value, want.norm_plain, want.norm_dead, want.percent,
                       result_mon.control_value, result_mon.norm_plain,
                       result_mon.norm_dead, result_mon.percent);
          end
        end
      end
    end
  end
endmodule

>>> verif/tb_rc_channel_pulse_scaler_unit.sv
// Top of the pulse scaler testbench: clock, reset, APB setup and stimulus.
// Depends on rcps_pkg, rcps_tb_pkg, the interfaces, the checker and the DUT.
`timescale 1ns / 1ps
module tb_rc_channel_pulse_scaler_unit;
  import rcps_pkg::*;
  import rcps_tb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  int fail_count, pending, idle_cycles;
  rcps_cal_t cal;

  // Directed pulse lists
  int unsigned dir_reset [11] = '{0, 4095, 1000, 2000, 1500, 1480, 1520, 1479, 1521, 999, 2001};
  int unsigned dir_range [7]  = '{0, 1, 2048, 4094, 4095, 2730, 1365};
  int unsigned dir_angle [7]  = '{0, 4095, 1500, 899, 2101, 3000, 700};

  rcps_pulse_if #(.PULSE_BITS(TB_PULSE_BITS)) pulse_ch();
  rcps_result_if result_ch();

  always #6 clk = ~clk;

  rc_channel_pulse_scaler_unit #(.PULSE_BITS(TB_PULSE_BITS)) u_dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .pulse(pulse_ch.sink), .result(result_ch.source)
  );

  rcps_reading_chk u_chk (
    .clk, .rst, .cal, .pulse_mon(pulse_ch.sink), .result_mon(result_ch.sink),
    .fail_count, .pending
  );

  // Watchdog: count cycles with no transfer on either channel and no APB access.
  always @(posedge clk) begin
    if (rst || (pulse_ch.valid && pulse_ch.ready) || (result_ch.valid && result_ch.ready) ||
        psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_MAX) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Sink side: hold ready low for a random stall before each transfer,
  // with some stretches of no stall at all.
  initial begin
    int stall;
    result_ch.ready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk iff result_ch.valid);
    end
  end

  // Write one register through a setup and an access cycle; mirror it locally.
  task automatic write_reg(rcps_reg_t idx, int unsigned value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * int'(idx)); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk iff pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_PULSE_MIN:  cal.pulse_min  = value & 12'hFFF;
      REG_PULSE_MAX:  cal.pulse_max  = value & 12'hFFF;
      REG_PULSE_TRIM: cal.pulse_trim = value & 12'hFFF;
      REG_DEAD_BAND:  cal.dead_band  = value & 10'h3FF;
      REG_INVERT:     cal.invert     = value & 1;
      REG_FULL_SCALE: cal.full_scale = value & 14'h3FFF;
      default:        cal.scale_mode = value & 1;
    endcase
  endtask

  task automatic set_cal(int unsigned mn, int unsigned mx, int unsigned tr, int unsigned db,
                         int unsigned inv, int unsigned fs, int unsigned md);
    write_reg(REG_PULSE_MIN, mn);
    write_reg(REG_PULSE_MAX, mx);
    write_reg(REG_PULSE_TRIM, tr);
    write_reg(REG_DEAD_BAND, db);
    write_reg(REG_INVERT, inv);
    write_reg(REG_FULL_SCALE, fs);
    write_reg(REG_SCALE_MODE, md);
  endtask

  // Send one pulse after a random gap; valid stays up across back-to-back items.
  task automatic send_pulse(int unsigned pw);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      pulse_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pulse_ch.valid <= 1'b1;
    pulse_ch.pulse_width <= pw[11:0];
    @(posedge clk iff pulse_ch.ready);
  endtask

  // Let the pipeline empty before touching registers.
  task automatic drain();
    pulse_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random pulse, weighted toward the calibrated window and its edges.
  function automatic int unsigned pick_pulse();
    int unsigned lo, hi;
    lo = (cal.pulse_min < cal.pulse_max) ? cal.pulse_min : cal.pulse_max;
    hi = (cal.pulse_min < cal.pulse_max) ? cal.pulse_max : cal.pulse_min;
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 4095);
      1: return cal.pulse_trim + $urandom_range(0, 2 * cal.dead_band + 2) - cal.dead_band - 1;
      default: return $urandom_range((lo > 50) ? lo - 50 : 0, (hi < 4045) ? hi + 50 : 4095);
    endcase
  endfunction

  initial begin
    int unsigned mn, mx, tr;
    cal = '{1000, 2000, 1500, 20, 0, 4500, 0};
    pulse_ch.valid = 1'b0;
    pulse_ch.pulse_width = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset calibration, field extremes and every special side.
    foreach (dir_reset[i])
      send_pulse(dir_reset[i]);
    drain();
    // Extreme registers: min above max, maximum scale, reversed, range mode.
    set_cal(4095, 0, 4095, 1023, 1, 16383, 1);
    foreach (dir_range[i])
      send_pulse(dir_range[i]);
    drain();
    // Angle with spans that flip the sign of the control value.
    set_cal(2000, 1000, 1500, 600, 0, 10000, 0);
    foreach (dir_angle[i])
      send_pulse(dir_angle[i]);
    drain();

    // Random phases of calibrated settings, mostly sane, some degenerate.
    for (int ph = 0; ph < 30; ph++) begin
      if ($urandom_range(0, 3) == 0) begin
        mn = $urandom_range(0, 4095); mx = $urandom_range(0, 4095); tr = $urandom_range(0, 4095);
      end else begin
        mn = $urandom_range(0, 1500); mx = $urandom_range(mn + 1, 4095);
        tr = $urandom_range(mn, mx);
      end
      set_cal(mn, mx, tr, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                                                      : $urandom_range(0, 60),
              $urandom_range(0, 1), $urandom_range(0, 16383), $urandom_range(0, 1));
      repeat (30) send_pulse(pick_pulse());
      drain();
    end

    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule
